@@ src/tvp_pkg.sv @@
// Shared constants and types for the trapezoidal velocity profile block.
// No dependencies; the files that use it refer to it by scoped names.
package tvp_pkg;

  localparam int WORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int TICK_WIDTH     = 16;
  localparam int CFG_IDX_WIDTH  = 2;

  localparam logic [TICK_WIDTH-1:0] TICK_RESET = 16'd655;

  // Configuration register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_DISTANCE = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_VELOCITY = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_ACCEL    = 2'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_TICK     = 2'd3;

  // Profile phase codes
  typedef enum logic [1:0] {
    PH_ACCEL  = 2'd0,
    PH_CRUISE = 2'd1,
    PH_DECEL  = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

endpackage

@@ src/tvp_in_if.sv @@
// Request channel carrying the restart flag.
// Depends on nothing.
interface tvp_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

@@ src/tvp_out_if.sv @@
// Result channel carrying one profile sample.
// Depends on tvp_pkg for the default word width.
interface tvp_out_if #(
  parameter int WORD_WIDTH = tvp_pkg::WORD_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic [WORD_WIDTH-1:0] sample_time;
  logic [WORD_WIDTH-1:0] velocity;
  logic [WORD_WIDTH-1:0] position;
  logic [1:0]            phase;
  logic                  last;

  modport source (output valid, output sample_time, output velocity, output position,
                  output phase, output last, input ready);
  modport sink   (input valid, input sample_time, input velocity, input position,
                  input phase, input last, output ready);
endinterface

@@ src/tvp_mul.sv @@
// Bit-serial fixed-point multiplier: one multiplier bit per cycle,
// result scaled down by FRAC_BITS and saturated. Uses tvp_pkg defaults.
module tvp_mul #(
  parameter int WORD_WIDTH = tvp_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = tvp_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [WORD_WIDTH-1:0] a,
  input  logic [WORD_WIDTH-1:0] b,
  output logic                  done,
  output logic [WORD_WIDTH-1:0] res
);
  localparam int W  = WORD_WIDTH;
  localparam int CW = $clog2(W);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [W-1:0]    mc_r, mc_nxt;
  logic [2*W-1:0]  pr_r, pr_nxt;
  logic [W:0]      sum;

  // Shift-add step
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mc_nxt   = mc_r;
    pr_nxt   = pr_r;
    sum      = {1'b0, pr_r[2*W-1:W]} + (pr_r[0] ? {1'b0, mc_r} : '0);
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      mc_nxt   = a;
      pr_nxt   = {{W{1'b0}}, b};
    end else if (busy_r) begin
      pr_nxt  = {sum, pr_r[W-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(W-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    mc_r  <= mc_nxt;
    pr_r  <= pr_nxt;
  end

  // Scale and saturate
  assign res  = (|pr_r[2*W-1:W+FRAC_BITS]) ? '1 : pr_r[W+FRAC_BITS-1:FRAC_BITS];
  assign done = done_r;

endmodule

@@ src/tvp_div.sv @@
// Restoring fixed-point divider, one quotient bit per cycle, saturating.
// A zero divisor yields the word maximum. Uses tvp_pkg defaults.
module tvp_div #(
  parameter int WORD_WIDTH = tvp_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = tvp_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [WORD_WIDTH-1:0] n,
  input  logic [WORD_WIDTH-1:0] d,
  output logic                  done,
  output logic [WORD_WIDTH-1:0] res
);
  localparam int W  = WORD_WIDTH;
  localparam int QW = WORD_WIDTH + FRAC_BITS;
  localparam int CW = $clog2(QW);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W:0]    rem_r, rem_nxt;
  logic [QW-1:0] nq_r, nq_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [W:0]    sh;
  logic          qb;

  // Shift in one numerator bit, trial subtract
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    nq_nxt   = nq_r;
    d_nxt    = d_r;
    sh       = {rem_r[W-1:0], nq_r[QW-1]};
    qb       = (sh >= {1'b0, d_r});
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      nq_nxt   = {n, {FRAC_BITS{1'b0}}};
      d_nxt    = d;
    end else if (busy_r) begin
      rem_nxt = qb ? (sh - {1'b0, d_r}) : sh;
      nq_nxt  = {nq_r[QW-2:0], qb};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(QW-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    nq_r  <= nq_nxt;
    d_r   <= d_nxt;
  end

  // Saturate the quotient to the word
  assign res  = (|nq_r[QW-1:W]) ? '1 : nq_r[W-1:0];
  assign done = done_r;

endmodule

@@ src/trapezoidal_velocity_profile_core.sv @@
// Trapezoidal velocity profile generator: sequencer around a serial
// multiplier and divider. Depends on tvp_pkg, tvp_in_if, tvp_out_if,
// tvp_mul and tvp_div.
//
// Usage: each request on in_ch carries restart. restart=1 plans a move from
// the configuration registers and returns the sample at time zero; restart=0
// advances time by one tick period unless the move has finished, and returns
// that sample. One sample per request leaves on out_ch. Registers are written
// on cfg_we; the user must write them only while idle, and the block itself
// does not enforce it. A tick request runs up to three products through the
// serial multiplier. A restart adds the plan: two divides, two products, and
// for a triangular move a third product and a square root that runs WORD_WIDTH
// trial squares through the multiplier.
// One request is worked on at a time; the next is taken while the previous
// sample still waits in the output register. If the receiver stalls, the
// finished sample holds there and the following one waits until it leaves.
// Reset (synchronous, rst_n low) loads the register defaults, clears the
// plan and drops any pending sample.
module trapezoidal_velocity_profile_core #(
  parameter int WORD_WIDTH = tvp_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = tvp_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tvp_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [WORD_WIDTH-1:0]             cfg_wdata,
  tvp_in_if.sink                            in_ch,
  tvp_out_if.source                         out_ch
);
  localparam int W  = WORD_WIDTH;
  localparam int TW = tvp_pkg::TICK_WIDTH;
  localparam int IW = $clog2(W);

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_ADV    = 16'h0002,
    S_DIV_TA = 16'h0004,
    S_MUL_AT = 16'h0008,
    S_MUL_DA = 16'h0010,
    S_CHK    = 16'h0020,
    S_DIV_DA = 16'h0040,
    S_SQ     = 16'h0080,
    S_MUL_VP = 16'h0100,
    S_DIV_TC = 16'h0200,
    S_FIN    = 16'h0400,
    S_SEL    = 16'h0800,
    S_MUL_V  = 16'h1000,
    S_MUL_P  = 16'h2000,
    S_MUL_Q  = 16'h4000,
    S_POS    = 16'h8000
  } state_t;

  function automatic logic [W-1:0] add_sat(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[W] ? '1 : s[W-1:0];
  endfunction

  function automatic logic [W-1:0] sub_floor(input logic [W-1:0] a, input logic [W-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  // Configuration registers
  logic [W-1:0]  dist_r, vlim_r, alim_r;
  logic [TW-1:0] tick_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= '0;
      vlim_r <= W'(1) << FRAC_BITS;
      alim_r <= W'(1) << FRAC_BITS;
      tick_r <= tvp_pkg::TICK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tvp_pkg::CFG_DISTANCE: dist_r <= cfg_wdata;
        tvp_pkg::CFG_VELOCITY: vlim_r <= cfg_wdata;
        tvp_pkg::CFG_ACCEL:    alim_r <= cfg_wdata;
        tvp_pkg::CFG_TICK:     tick_r <= cfg_wdata[TW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state
  state_t        state_r, state_nxt;
  logic          issued_r, issued_nxt;
  logic [W-1:0]  t_r, t_nxt;
  logic [W-1:0]  aet_r, aet_nxt, cet_r, cet_nxt, tot_r, tot_nxt;
  logic [W-1:0]  vp_r, vp_nxt, da_r, da_nxt, dc_r, dc_nxt;
  logic          fin_r, fin_nxt;
  // Working values
  logic [W-1:0]  ta_r, ta_nxt, tc_r, tc_nxt, x_r, x_nxt, rt_r, rt_nxt;
  logic [IW-1:0] sqi_r, sqi_nxt;
  logic [W-1:0]  u_r, u_nxt, v_r, v_nxt, au_r, au_nxt, m_r, m_nxt;
  logic [W-1:0]  qq_r, qq_nxt, dd_r, dd_nxt;
  tvp_pkg::phase_t ph_r, ph_nxt;
  // Output register
  logic          ov_r, ov_nxt;
  logic [W-1:0]  ot_r, ot_nxt, ovel_r, ovel_nxt, opos_r, opos_nxt;
  tvp_pkg::phase_t oph_r, oph_nxt;
  logic          olast_r, olast_nxt;

  // Arithmetic units
  logic          mul_go, div_go, mul_done, div_done;
  logic [W-1:0]  mul_a, mul_b, mul_res, div_n, div_d, div_res;
  logic [W-1:0]  cand;
  logic [W:0]    da2;
  logic [W-1:0]  pos, pos_c;
  logic          out_free, in_fire;

  tvp_mul #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_go), .a(mul_a), .b(mul_b),
    .done(mul_done), .res(mul_res)
  );

  tvp_div #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go), .n(div_n), .d(div_d),
    .done(div_done), .res(div_res)
  );

  assign cand     = rt_r | (W'(1) << sqi_r);
  assign da2      = {da_r, 1'b0};
  assign out_free = !ov_r || out_ch.ready;
  assign in_fire  = in_ch.valid && in_ch.ready;

  // Select unit operands per step
  always_comb begin
    mul_a = alim_r;
    mul_b = t_r;
    div_n = vlim_r;
    div_d = alim_r;
    unique case (state_r)
      S_MUL_AT: mul_b = ta_r;
      S_MUL_DA: begin
        mul_a = x_r;
        mul_b = ta_r;
      end
      S_SQ: begin
        mul_a = cand;
        mul_b = cand;
      end
      S_MUL_VP: mul_b = ta_r;
      S_MUL_V:  mul_b = (ph_r == tvp_pkg::PH_ACCEL) ? t_r : u_r;
      S_MUL_P: begin
        mul_a = (ph_r == tvp_pkg::PH_ACCEL) ? v_r : vp_r;
        mul_b = (ph_r == tvp_pkg::PH_ACCEL) ? t_r : u_r;
      end
      S_MUL_Q: begin
        mul_a = au_r;
        mul_b = u_r;
      end
      S_DIV_DA: div_n = dist_r;
      S_DIV_TC: begin
        div_n = dc_r;
        div_d = vlim_r;
      end
      default: ;
    endcase
  end

  assign mul_go = !issued_r && (state_r == S_MUL_AT || state_r == S_MUL_DA ||
                  state_r == S_SQ || state_r == S_MUL_VP || state_r == S_MUL_V ||
                  state_r == S_MUL_P || state_r == S_MUL_Q);
  assign div_go = !issued_r && (state_r == S_DIV_TA || state_r == S_DIV_DA ||
                  state_r == S_DIV_TC);

  // Position before and after clamping
  always_comb begin
    case (ph_r)
      tvp_pkg::PH_ACCEL:  pos = m_r >> 1;
      tvp_pkg::PH_CRUISE: pos = add_sat(da_r, m_r);
      tvp_pkg::PH_DECEL:  pos = sub_floor(add_sat(dd_r, m_r), qq_r >> 1);
      default:            pos = dist_r;
    endcase
    pos_c = (pos > dist_r) ? dist_r : pos;
  end

  // Step the sequencer
  always_comb begin
    state_nxt = state_r;
    issued_nxt = issued_r;
    t_nxt = t_r;   aet_nxt = aet_r; cet_nxt = cet_r; tot_nxt = tot_r;
    vp_nxt = vp_r; da_nxt = da_r;   dc_nxt = dc_r;   fin_nxt = fin_r;
    ta_nxt = ta_r; tc_nxt = tc_r;   x_nxt = x_r;     rt_nxt = rt_r;
    sqi_nxt = sqi_r; u_nxt = u_r;   v_nxt = v_r;     au_nxt = au_r;
    m_nxt = m_r;   qq_nxt = qq_r;   dd_nxt = dd_r;   ph_nxt = ph_r;
    ov_nxt = ov_r; ot_nxt = ot_r;   ovel_nxt = ovel_r; opos_nxt = opos_r;
    oph_nxt = oph_r; olast_nxt = olast_r;

    if (mul_go || div_go) issued_nxt = 1'b1;
    if (mul_done || div_done) issued_nxt = 1'b0;
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = in_ch.restart ? S_DIV_TA : S_ADV;
      end
      S_ADV: begin
        if (!fin_r) t_nxt = add_sat(t_r, {{(W-TW){1'b0}}, tick_r});
        state_nxt = S_SEL;
      end
      S_DIV_TA: begin
        if (div_done) begin
          ta_nxt = div_res;
          state_nxt = S_MUL_AT;
        end
      end
      S_MUL_AT: begin
        if (mul_done) begin
          x_nxt = mul_res;
          state_nxt = S_MUL_DA;
        end
      end
      S_MUL_DA: begin
        if (mul_done) begin
          da_nxt = mul_res >> 1;
          state_nxt = S_CHK;
        end
      end
      // Triangular when twice the ramp distance overshoots the move
      S_CHK: begin
        if (da2 > {1'b0, dist_r}) begin
          state_nxt = S_DIV_DA;
        end else begin
          vp_nxt = vlim_r;
          dc_nxt = dist_r - da2[W-1:0];
          state_nxt = S_DIV_TC;
        end
      end
      S_DIV_DA: begin
        if (div_done) begin
          x_nxt = div_res;
          rt_nxt = '0;
          sqi_nxt = IW'(W-1);
          state_nxt = S_SQ;
        end
      end
      // Square root, one result bit per trial square
      S_SQ: begin
        if (mul_done) begin
          if (mul_res <= x_r) rt_nxt = cand;
          if (sqi_r == '0) begin
            ta_nxt = (mul_res <= x_r) ? cand : rt_r;
            state_nxt = S_MUL_VP;
          end else begin
            sqi_nxt = sqi_r - 1'b1;
          end
        end
      end
      S_MUL_VP: begin
        if (mul_done) begin
          vp_nxt = mul_res;
          da_nxt = dist_r >> 1;
          dc_nxt = '0;
          tc_nxt = '0;
          state_nxt = S_FIN;
        end
      end
      S_DIV_TC: begin
        if (div_done) begin
          tc_nxt = div_res;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        aet_nxt = ta_r;
        cet_nxt = add_sat(ta_r, tc_r);
        tot_nxt = add_sat(add_sat(ta_r, ta_r), tc_r);
        t_nxt = '0;
        fin_nxt = 1'b0;
        state_nxt = S_SEL;
      end
      // Pick the phase for the current time
      S_SEL: begin
        dd_nxt = add_sat(da_r, dc_r);
        if (t_r < aet_r) begin
          ph_nxt = tvp_pkg::PH_ACCEL;
          state_nxt = S_MUL_V;
        end else if (t_r < cet_r) begin
          ph_nxt = tvp_pkg::PH_CRUISE;
          v_nxt = vp_r;
          u_nxt = t_r - aet_r;
          state_nxt = S_MUL_P;
        end else if (t_r < tot_r) begin
          ph_nxt = tvp_pkg::PH_DECEL;
          u_nxt = t_r - cet_r;
          state_nxt = S_MUL_V;
        end else begin
          ph_nxt = tvp_pkg::PH_DONE;
          v_nxt = '0;
          state_nxt = S_POS;
        end
      end
      S_MUL_V: begin
        if (mul_done) begin
          au_nxt = mul_res;
          v_nxt = (ph_r == tvp_pkg::PH_ACCEL) ? mul_res : sub_floor(vp_r, mul_res);
          state_nxt = S_MUL_P;
        end
      end
      S_MUL_P: begin
        if (mul_done) begin
          m_nxt = mul_res;
          state_nxt = (ph_r == tvp_pkg::PH_DECEL) ? S_MUL_Q : S_POS;
        end
      end
      S_MUL_Q: begin
        if (mul_done) begin
          qq_nxt = mul_res;
          state_nxt = S_POS;
        end
      end
      // Load the sample once the output register is free
      S_POS: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          ot_nxt = t_r;
          ovel_nxt = v_r;
          opos_nxt = pos_c;
          oph_nxt = ph_r;
          olast_nxt = (t_r > tot_r) || (t_r == '1);
          if ((t_r > tot_r) || (t_r == '1)) fin_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      issued_r <= 1'b0;
      ov_r     <= 1'b0;
      t_r      <= '0;
      aet_r    <= '0;
      cet_r    <= '0;
      tot_r    <= '0;
      vp_r     <= '0;
      da_r     <= '0;
      dc_r     <= '0;
      fin_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;
      ov_r     <= ov_nxt;
      t_r      <= t_nxt;
      aet_r    <= aet_nxt;
      cet_r    <= cet_nxt;
      tot_r    <= tot_nxt;
      vp_r     <= vp_nxt;
      da_r     <= da_nxt;
      dc_r     <= dc_nxt;
      fin_r    <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ta_r    <= ta_nxt;
    tc_r    <= tc_nxt;
    x_r     <= x_nxt;
    rt_r    <= rt_nxt;
    sqi_r   <= sqi_nxt;
    u_r     <= u_nxt;
    v_r     <= v_nxt;
    au_r    <= au_nxt;
    m_r     <= m_nxt;
    qq_r    <= qq_nxt;
    dd_r    <= dd_nxt;
    ph_r    <= ph_nxt;
    ot_r    <= ot_nxt;
    ovel_r  <= ovel_nxt;
    opos_r  <= opos_nxt;
    oph_r   <= oph_nxt;
    olast_r <= olast_nxt;
  end

  // Channel drive
  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = ov_r;
  assign out_ch.sample_time = ot_r;
  assign out_ch.velocity    = ovel_r;
  assign out_ch.position    = opos_r;
  assign out_ch.phase       = oph_r;
  assign out_ch.last        = olast_r;

  // Checks
  a_plan_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cet_r >= aet_r) && (tot_r >= cet_r))
    else $error("plan boundaries out of order");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && olast_r) |-> (oph_r == tvp_pkg::PH_DONE))
    else $error("last sample not in done phase");

  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_IDLE))
    else $error("request accepted without starting work");

  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_go && div_go))
    else $error("multiplier and divider started together");

endmodule
